@@ design/suis_pkg.sv @@
// ----------------------------------------------------------------------------
// suis_pkg
// Shared types and constants of the sorted unique integer set.
// ----------------------------------------------------------------------------
package suis_pkg;

  // Store geometry
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the item channels
  localparam int unsigned VAL_W     = 31;
  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STATUS_W  = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_NEG    = 3'd1,
    ST_DUP    = 3'd2,
    ST_ABSENT = 3'd3,
    ST_FULL   = 3'd4,
    ST_RANGE  = 3'd5
  } status_e;

  // Access request to the element store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ design/suis_req_if.sv @@
// ----------------------------------------------------------------------------
// suis_req_if
// Request channel: mode, value and index with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface suis_req_if;
  import suis_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic signed [31:0]  value;
  logic [INDEX_W-1:0]  index;

  modport source (output valid, output mode, output value, output index, input ready);
  modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

@@ design/suis_rsp_if.sv @@
// ----------------------------------------------------------------------------
// suis_rsp_if
// Response channel: status, found flag, entry and count with valid/ready.
// ----------------------------------------------------------------------------
interface suis_rsp_if;
  import suis_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [VAL_W-1:0]    entry;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output found, output entry, output count,
                  input ready);
  modport sink   (input valid, input status, input found, input entry, input count,
                  output ready);
endinterface

@@ design/suis_store.sv @@
// ----------------------------------------------------------------------------
// suis_store
// Element store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module suis_store (
  input  logic                       clk_i,
  input  suis_pkg::mem_req_t         req_i,
  output logic [suis_pkg::VAL_W-1:0] rdata_o
);
  import suis_pkg::*;

  logic [VAL_W-1:0] mem_q [CAPACITY];
  logic [VAL_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port, data valid the cycle after the request
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/sorted_unique_integer_set.sv @@
// ----------------------------------------------------------------------------
// sorted_unique_integer_set
// Ascending set of distinct non-negative integers in a store with one read and one write port.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one item per request: mode (add, remove, find, read),
//   value and index. rsp_o returns one item per request: status, found,
//   entry and the element count after the request.
//   The block takes one request at a time; req_i.ready is high only while
//   the sequencer is idle. A scan walks the store one entry per cycle from
//   the bottom until it meets the first entry not below the value; add and
//   remove then move the entries above that place one per cycle through the
//   single read and single write port of the store.
//   Path from accept to the response item: a negative value or a read index
//   out of range goes straight to the output stage, a read waits for the
//   store read data; find, duplicate, full or absent go through the scan
//   and the decision; add and remove then shift the entries. The next
//   request can be taken in the cycle after the response item is loaded.
//   The response sits in an output register; a new request is accepted as
//   soon as the sequencer is idle, even while that response waits. If the
//   receiver stalls, a finished request holds in its last state until the
//   output register frees up.
//   Reset empties the set at once (count zero); store contents are left as
//   they are and are only read below the count.
// ----------------------------------------------------------------------------
module sorted_unique_integer_set (
  input  logic        clk_i,
  input  logic        rst_ni,
  suis_req_if.sink    req_i,
  suis_rsp_if.source  rsp_o
);
  import suis_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_RD_WAIT,
    S_DONE
  } state_e;

  state_e            state_q;
  mode_e             mode_q;
  logic [VAL_W-1:0]  val_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  ptr_q;
  logic              rvalid_q;
  logic [CNT_W-1:0]  raddr_q;
  logic [CNT_W-1:0]  pos_q;
  logic              present_q;
  logic [CNT_W-1:0]  sh_k_q;
  logic              wpend_q;
  logic [CNT_W-1:0]  waddr_q;
  status_e           stat_q;
  logic              found_q;
  logic [VAL_W-1:0]  entry_q;

  logic                ov_q;
  logic [STATUS_W-1:0] ost_q;
  logic                ofound_q;
  logic [VAL_W-1:0]    oentry_q;
  logic [COUNT_W-1:0]  ocnt_q;

  mem_req_t          mreq;
  logic [VAL_W-1:0]  rdata;
  logic              accept;
  logic              idx_ok;
  logic              s_hit;
  logic              s_end;
  logic              out_free;
  logic              up_more;
  logic              dn_more;

  assign accept   = req_i.valid && req_i.ready;
  assign idx_ok   = CNT_W'(req_i.index) < cnt_q;
  assign out_free = !ov_q || rsp_o.ready;

  // Scan stops at the first entry not below the value, or past the count
  assign s_hit   = rvalid_q && !(rdata < val_q);
  assign s_end   = !rvalid_q && (ptr_q >= cnt_q);
  assign up_more = sh_k_q > pos_q;
  assign dn_more = CNT_W'(sh_k_q + 1'b1) < cnt_q;

  // Store access per state
  always_comb begin
    mreq = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && mode_e'(req_i.mode) == MODE_READ && idx_ok) begin
          mreq.re    = 1'b1;
          mreq.raddr = IDX_W'(req_i.index);
        end
      end
      S_SEARCH: begin
        if (ptr_q < cnt_q) begin
          mreq.re    = 1'b1;
          mreq.raddr = IDX_W'(ptr_q);
        end
      end
      S_SHIFT_UP: begin
        if (wpend_q) begin
          mreq.we    = 1'b1;
          mreq.waddr = IDX_W'(waddr_q);
          mreq.wdata = rdata;
        end else if (!up_more) begin
          mreq.we    = 1'b1;
          mreq.waddr = IDX_W'(pos_q);
          mreq.wdata = val_q;
        end
        if (up_more) begin
          mreq.re    = 1'b1;
          mreq.raddr = IDX_W'(CNT_W'(sh_k_q - 1'b1));
        end
      end
      S_SHIFT_DN: begin
        if (wpend_q) begin
          mreq.we    = 1'b1;
          mreq.waddr = IDX_W'(waddr_q);
          mreq.wdata = rdata;
        end
        if (dn_more) begin
          mreq.re    = 1'b1;
          mreq.raddr = IDX_W'(CNT_W'(sh_k_q + 1'b1));
        end
      end
      S_DECIDE, S_RD_WAIT, S_DONE: begin
        mreq = '0;
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  suis_store u_store (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      ptr_q     <= '0;
      rvalid_q  <= 1'b0;
      wpend_q   <= 1'b0;
      ov_q      <= 1'b0;
      mode_q    <= MODE_ADD;
      stat_q    <= ST_OK;
      found_q   <= 1'b0;
      present_q <= 1'b0;
    end else begin
      // output register empties when taken, unless reloaded below
      if (rsp_o.ready && state_q != S_DONE) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q   <= mode_e'(req_i.mode);
            val_q    <= req_i.value[VAL_W-1:0];
            found_q  <= 1'b0;
            entry_q  <= '0;
            stat_q   <= ST_OK;
            ptr_q    <= '0;
            rvalid_q <= 1'b0;
            if (mode_e'(req_i.mode) == MODE_READ) begin
              if (idx_ok) begin
                state_q <= S_RD_WAIT;
              end else begin
                stat_q  <= ST_RANGE;
                state_q <= S_DONE;
              end
            end else if (req_i.value[31]) begin
              stat_q  <= ST_NEG;
              state_q <= S_DONE;
            end else begin
              state_q <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          rvalid_q <= mreq.re;
          raddr_q  <= ptr_q;
          if (mreq.re) begin
            ptr_q <= CNT_W'(ptr_q + 1'b1);
          end
          if (s_hit) begin
            pos_q     <= raddr_q;
            present_q <= (rdata == val_q);
            state_q   <= S_DECIDE;
          end else if (s_end) begin
            pos_q     <= cnt_q;
            present_q <= 1'b0;
            state_q   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          wpend_q <= 1'b0;
          unique case (mode_q)
            MODE_FIND: begin
              found_q <= present_q;
              state_q <= S_DONE;
            end
            MODE_ADD: begin
              if (present_q) begin
                stat_q  <= ST_DUP;
                state_q <= S_DONE;
              end else if (cnt_q >= CNT_W'(CAPACITY)) begin
                stat_q  <= ST_FULL;
                state_q <= S_DONE;
              end else begin
                sh_k_q  <= cnt_q;
                state_q <= S_SHIFT_UP;
              end
            end
            MODE_REMOVE: begin
              if (!present_q) begin
                stat_q  <= ST_ABSENT;
                state_q <= S_DONE;
              end else begin
                sh_k_q  <= pos_q;
                state_q <= S_SHIFT_DN;
              end
            end
            MODE_READ: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_SHIFT_UP: begin
          wpend_q <= mreq.re;
          waddr_q <= sh_k_q;
          if (mreq.re) begin
            sh_k_q <= CNT_W'(sh_k_q - 1'b1);
          end
          if (!wpend_q && !up_more) begin
            cnt_q   <= CNT_W'(cnt_q + 1'b1);
            state_q <= S_DONE;
          end
        end
        S_SHIFT_DN: begin
          wpend_q <= mreq.re;
          waddr_q <= sh_k_q;
          if (mreq.re) begin
            sh_k_q <= CNT_W'(sh_k_q + 1'b1);
          end
          if (!wpend_q && !dn_more) begin
            cnt_q   <= CNT_W'(cnt_q - 1'b1);
            state_q <= S_DONE;
          end
        end
        S_RD_WAIT: begin
          entry_q <= rdata;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            ov_q     <= 1'b1;
            ost_q    <= stat_q;
            ofound_q <= found_q;
            oentry_q <= entry_q;
            ocnt_q   <= COUNT_W'(cnt_q);
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = ov_q;
  assign rsp_o.status = ost_q;
  assign rsp_o.found  = ofound_q;
  assign rsp_o.entry  = oentry_q;
  assign rsp_o.count  = ocnt_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("element count beyond capacity");

  a_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mreq.we && mreq.re) |-> (mreq.waddr != mreq.raddr))
    else $error("store read and write hit the same entry");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ost_q == ST_FULL) |-> (ocnt_q == COUNT_W'(CAPACITY)))
    else $error("full status with store not full");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ofound_q) |-> (ost_q == ST_OK))
    else $error("found flag with error status");

  a_range_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ost_q != ST_OK) |-> (oentry_q == '0))
    else $error("entry nonzero on error");

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the sorted unique integer set against a behavioral model of the
// ordered store. A queued driver and a monitor exercise both handshakes
// with random idling. The monitor compares every response item field by
// field with the predicted one. The random traffic alternates fill, mixed
// and drain rounds so that the store reaches full and empty repeatedly.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import suis_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1100;
  localparam int unsigned POOL_SIZE      = 96;
  localparam int unsigned IDLE_PCT       = 15;
  localparam int unsigned HOLDOFF_AT     = 250;
  localparam int unsigned HOLDOFF_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct {
    mode_e              mode;
    logic signed [31:0] value;
    logic [INDEX_W-1:0] index;
    bit                 sync;   // hold off until all responses are back
  } set_request_t;

  typedef struct {
    status_e            status;
    logic               found;
    logic [VAL_W-1:0]   entry;
    logic [COUNT_W-1:0] count;
  } set_response_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  suis_req_if req_if ();
  suis_rsp_if rsp_if ();

  sorted_unique_integer_set dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // Model of the ordered store
  logic [VAL_W-1:0] model_vals [CAPACITY];
  int unsigned      model_size;

  set_request_t  pending_reqs [$];
  set_response_t expected_rsps [$];

  set_request_t  taken_req;
  set_response_t want_rsp;
  bit            req_taken;
  int unsigned   reqs_sent;
  int unsigned   rsps_seen;
  int unsigned   quiet_cycles;
  int unsigned   mismatches;
  int unsigned   hold_left;
  bit            hold_done;
  bit            timed_out;
  logic signed [31:0] value_pool [POOL_SIZE];

  // Expected response of one request; updates the model store
  function automatic set_response_t apply_request(input set_request_t r);
    set_response_t    res;
    int unsigned      pos;
    int unsigned      k;
    bit               hit;
    logic [VAL_W-1:0] v;
    res = '{ST_OK, 1'b0, '0, '0};
    v = r.value[VAL_W-1:0];
    if (r.mode == MODE_READ) begin
      if (r.index < model_size) res.entry = model_vals[r.index];
      else res.status = ST_RANGE;
    end else if (r.value[31]) begin
      res.status = ST_NEG;
    end else begin
      // first position not below the value
      pos = 0;
      while (pos < model_size && model_vals[pos] < v) pos++;
      hit = (pos < model_size) && (model_vals[pos] == v);
      case (r.mode)
        MODE_ADD: begin
          if (hit) begin
            res.status = ST_DUP;
          end else if (model_size >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            for (k = model_size; k > pos; k--) model_vals[k] = model_vals[k-1];
            model_vals[pos] = v;
            model_size++;
          end
        end
        MODE_REMOVE: begin
          if (!hit) begin
            res.status = ST_ABSENT;
          end else begin
            for (k = pos; k + 1 < model_size; k++) model_vals[k] = model_vals[k+1];
            model_size--;
          end
        end
        default: res.found = hit;
      endcase
    end
    res.count = model_size[COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch after %0d responses: %s", rsps_seen, msg);
    mismatches++;
  endtask

  task automatic queue_request(input mode_e m, input logic signed [31:0] v,
                               input int unsigned idx, input bit sync = 1'b0);
    set_request_t r;
    r.mode  = m;
    r.value = v;
    r.index = idx[INDEX_W-1:0];
    r.sync  = sync;
    pending_reqs.push_back(r);
  endtask

  // One round of random requests drawn mostly from a shared value pool
  task automatic queue_round(input int unsigned n, input int unsigned add_pct,
                             input int unsigned rem_pct, input int unsigned find_pct);
    int unsigned        i;
    int unsigned        pick;
    mode_e              m;
    logic signed [31:0] v;
    for (i = 0; i < POOL_SIZE; i++) begin
      if ($urandom_range(2) == 0) value_pool[i] = $urandom_range(200);
      else value_pool[i] = $urandom & 32'h7fff_ffff;
    end
    value_pool[0] = 32'sd0;
    value_pool[1] = 32'h7fff_ffff;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < add_pct) m = MODE_ADD;
      else if (pick < add_pct + rem_pct) m = MODE_REMOVE;
      else if (pick < add_pct + rem_pct + find_pct) m = MODE_FIND;
      else m = MODE_READ;
      if (m == MODE_READ) v = $urandom;
      else if ($urandom_range(99) < 6) v = $urandom | 32'h8000_0000;
      else v = value_pool[$urandom_range(POOL_SIZE - 1)];
      queue_request(m, v, $urandom_range(63), i == 0);
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (req_if.valid && req_if.ready) begin
        taken_req = pending_reqs.pop_front();
        expected_rsps.push_back(apply_request(taken_req));
        req_taken = 1'b1;
        reqs_sent++;
        quiet_cycles = 0;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        quiet_cycles = 0;
        if (expected_rsps.size() == 0) begin
          report_mismatch("response item with none expected");
        end else begin
          want_rsp = expected_rsps.pop_front();
          if (rsp_if.status !== want_rsp.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_if.status, want_rsp.status));
          if (rsp_if.found !== want_rsp.found)
            report_mismatch($sformatf("found %0d, expected %0d",
                                      rsp_if.found, want_rsp.found));
          if (rsp_if.entry !== want_rsp.entry)
            report_mismatch($sformatf("entry %0d, expected %0d",
                                      rsp_if.entry, want_rsp.entry));
          if (rsp_if.count !== want_rsp.count)
            report_mismatch($sformatf("count %0d, expected %0d",
                                      rsp_if.count, want_rsp.count));
        end
        rsps_seen++;
      end
    end
  end

  // Request driver: next item at the falling edge, random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!req_if.valid || req_taken)) begin
      req_taken = 1'b0;
      if (pending_reqs.size() != 0 &&
          !(pending_reqs[0].sync && expected_rsps.size() != 0) &&
          ((reqs_sent >= 400 && reqs_sent < 550) || $urandom_range(99) >= IDLE_PCT)) begin
        req_if.valid <= 1'b1;
        req_if.mode  <= pending_reqs[0].mode;
        req_if.value <= pending_reqs[0].value;
        req_if.index <= pending_reqs[0].index;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response ready: random stalls, one long hold-off, one quiet stretch
  always @(negedge clk_i) begin
    if (!hold_done && rsps_seen >= HOLDOFF_AT) begin
      hold_left = HOLDOFF_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (rsps_seen >= 700 && rsps_seen < 850) begin
      rsp_if.ready <= 1'b1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.mode  = MODE_ADD;
    req_if.value = '0;
    req_if.index = '0;
    rsp_if.ready = 1'b0;
    model_size   = 0;
    req_taken    = 1'b0;
    reqs_sent    = 0;
    rsps_seen    = 0;
    quiet_cycles = 0;
    mismatches   = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    timed_out    = 1'b0;

    // Directed: empty store, extremes, duplicates, negatives, index range
    queue_request(MODE_READ,   32'sd0, 0);
    queue_request(MODE_REMOVE, 32'sd5, 0);
    queue_request(MODE_FIND,   32'sd5, 0);
    queue_request(MODE_ADD,    32'sd0, 0);
    queue_request(MODE_ADD,    32'h7fff_ffff, 0);
    queue_request(MODE_ADD,    32'h8000_0000, 0);
    queue_request(MODE_ADD,    -32'sd1, 63);
    queue_request(MODE_ADD,    32'sd0, 0);
    queue_request(MODE_ADD,    32'sd1000, 0);
    queue_request(MODE_FIND,   32'sd1000, 0);
    queue_request(MODE_FIND,   32'sd999, 0);
    queue_request(MODE_FIND,   -32'sd5, 0);
    queue_request(MODE_REMOVE, -32'sd1, 0);
    queue_request(MODE_READ,   32'hffff_ffff, 0);
    queue_request(MODE_READ,   32'sd0, 2);
    queue_request(MODE_READ,   32'sd0, 3);
    queue_request(MODE_READ,   32'sd0, 63);
    queue_request(MODE_REMOVE, 32'sd1000, 0);
    queue_request(MODE_REMOVE, 32'sd1000, 0);
    queue_request(MODE_ADD,    32'h5555_5555, 0);
    queue_request(MODE_ADD,    32'h2aaa_aaaa, 0);
    queue_request(MODE_READ,   32'h5555_5555, 1);
    queue_request(MODE_READ,   32'sd0, 42);

    // Random: fill to full, mixed traffic, drain toward empty
    while (pending_reqs.size() < RANDOM_ITEMS) begin
      queue_round(150, 85, 5, 5);
      queue_round(100, 35, 35, 15);
      queue_round(150, 10, 70, 10);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    fork
      begin
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
        repeat (SETTLE_CYCLES) @(posedge clk_i);
      end
      begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
        timed_out = 1'b1;
      end
    join_any

    if (timed_out || mismatches != 0) begin
      $display("tb: failure");
    end else begin
      $display("tb: success");
    end
    $finish;
  end

endmodule
